>>> rtl/ccw_pkg.sv
// ----------------------------------------------------------------------------
// ccw_pkg: calendar clock shared types and constants
// Request and result layouts, clock state, stage hand-off types and limits.
// ----------------------------------------------------------------------------
package ccw_pkg;

    localparam logic        MODE_TICK = 1'b0;
    localparam logic        MODE_SET  = 1'b1;

    localparam logic [7:0]  SET_BYTES   = 8'd6;
    localparam logic [15:0] YEAR_BASE   = 16'd2000;

    localparam logic [3:0]  MONTH_FIRST = 4'd1;
    localparam logic [3:0]  MONTH_FEB   = 4'd2;
    localparam logic [3:0]  MONTH_LAST  = 4'd12;
    localparam logic [4:0]  DAY_FIRST   = 5'd1;
    localparam logic [4:0]  DAY_MAX     = 5'd31;
    localparam logic [4:0]  HOUR_LAST   = 5'd23;
    localparam logic [5:0]  MIN_LAST    = 6'd59;
    localparam logic [5:0]  SEC_LAST    = 6'd59;
    localparam logic [2:0]  WDAY_LAST   = 3'd6;

    localparam logic [15:0] YEAR_RST    = 16'd2000;

    typedef struct packed {
        logic       mode;
        logic [7:0] byte_count;
        logic [7:0] year_offset;
        logic [7:0] set_month;
        logic [7:0] set_day;
        logic [7:0] set_hour;
        logic [7:0] set_minute;
        logic [7:0] set_second;
    } t_in_item;

    typedef struct packed {
        logic [15:0] cur_year;
        logic [3:0]  cur_month;
        logic [4:0]  cur_day;
        logic [4:0]  cur_hour;
        logic [5:0]  cur_minute;
        logic [5:0]  cur_second;
        logic [2:0]  weekday;
        logic        set_rejected;
        logic        day_rolled;
    } t_out_item;

    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_clk_state;

    typedef struct packed {
        t_clk_state clk;
        logic       rejected;
        logic       rolled;
    } t_stamp;

endpackage

>>> rtl/calendar_clock_with_weekday.sv
// ----------------------------------------------------------------------------
// calendar_clock_with_weekday: calendar clock with day of week
// Gregorian clock advanced by tick requests or loaded by set requests.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  request   i_in_valid / o_in_ready / i_in_item       in
//  result    o_out_valid / i_out_ready / o_out_item    out
//
//  One request per cycle while results are taken; each request passes through the
//  input register, counter stage, weekday quotient stage and mod 7 stage.
//  Reset: pipeline empty, clock at 2000-01-01 00:00:00.
//  A held result stalls the stages behind it; requests are taken until
//  all four registers are full.
// ----------------------------------------------------------------------------
module calendar_clock_with_weekday
    import ccw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_in_item r_in;
    logic     r_in_vld;
    logic     cnt_rdy, cnt_vld, wd_rdy;
    t_stamp   stamp;

    assign o_in_ready = !r_in_vld || cnt_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    ccw_count u_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_in_vld),
        .i_item  (r_in),
        .o_rdy   (cnt_rdy),
        .o_vld   (cnt_vld),
        .o_stamp (stamp),
        .i_rdy   (wd_rdy)
    );

    ccw_weekday u_weekday (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (cnt_vld),
        .i_stamp (stamp),
        .o_rdy   (wd_rdy),
        .o_vld   (o_out_valid),
        .o_item  (o_out_item),
        .i_rdy   (i_out_ready)
    );

endmodule

>>> rtl/ccw_count.sv
// ----------------------------------------------------------------------------
// ccw_count: calendar counter stage
// Holds the clock state; applies one tick or one validated set per request.
// ----------------------------------------------------------------------------
module ccw_count
    import ccw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_vld,
    input  t_in_item i_item,
    output logic     o_rdy,
    output logic     o_vld,
    output t_stamp   o_stamp,
    input  logic     i_rdy
);

    localparam logic [14:0] RECIP_25 = 15'd20972;
    localparam int          RECIP_SH = 19;

    function automatic logic is_leap(input logic [15:0] y);
        logic [30:0] prod;
        logic [11:0] q;
        logic [15:0] rem;
        prod = 31'(y) * 31'(RECIP_25);
        q    = prod[RECIP_SH +: 12];
        rem  = y - 16'(17'(q) * 17'd25);
        return (y[1:0] == 2'b00) && ((rem != 16'd0) || (y[3:0] == 4'd0));
    endfunction

    t_clk_state r_clk, n_clk;
    logic       r_vld, r_rej, r_roll;
    logic       n_rej, n_roll;
    logic       leap, set_ok, take;
    logic [4:0] dim;

    assign leap = is_leap(r_clk.year);

    always_comb begin
        case (r_clk.month)
            MONTH_FEB: dim = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: dim = 5'd30;
            default: dim = DAY_MAX;
        endcase
    end

    assign set_ok = (i_item.byte_count == SET_BYTES)
                 && (i_item.set_month >= 8'(MONTH_FIRST)) && (i_item.set_month <= 8'(MONTH_LAST))
                 && (i_item.set_day >= 8'(DAY_FIRST)) && (i_item.set_day <= 8'(DAY_MAX))
                 && (i_item.set_hour <= 8'(HOUR_LAST))
                 && (i_item.set_minute <= 8'(MIN_LAST))
                 && (i_item.set_second <= 8'(SEC_LAST));

    always_comb begin
        n_clk  = r_clk;
        n_rej  = 1'b0;
        n_roll = 1'b0;
        if (i_item.mode == MODE_TICK) begin
            if (r_clk.second >= SEC_LAST) begin
                n_clk.second = '0;
                if (r_clk.minute >= MIN_LAST) begin
                    n_clk.minute = '0;
                    if (r_clk.hour >= HOUR_LAST) begin
                        n_clk.hour = '0;
                        n_roll     = 1'b1;
                        if (r_clk.day >= dim) begin
                            n_clk.day = DAY_FIRST;
                            if (r_clk.month >= MONTH_LAST) begin
                                n_clk.month = MONTH_FIRST;
                                n_clk.year  = r_clk.year + 16'd1;
                            end else begin
                                n_clk.month = r_clk.month + 4'd1;
                            end
                        end else begin
                            n_clk.day = r_clk.day + 5'd1;
                        end
                    end else begin
                        n_clk.hour = r_clk.hour + 5'd1;
                    end
                end else begin
                    n_clk.minute = r_clk.minute + 6'd1;
                end
            end else begin
                n_clk.second = r_clk.second + 6'd1;
            end
        end else if (set_ok) begin
            n_clk.year   = 16'(i_item.year_offset) + YEAR_BASE;
            n_clk.month  = i_item.set_month[3:0];
            n_clk.day    = i_item.set_day[4:0];
            n_clk.hour   = i_item.set_hour[4:0];
            n_clk.minute = i_item.set_minute[5:0];
            n_clk.second = i_item.set_second[5:0];
        end else begin
            n_rej = 1'b1;
        end
    end

    assign o_rdy = !r_vld || i_rdy;
    assign take  = i_vld && o_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= 1'b0;
            r_clk.year   <= YEAR_RST;
            r_clk.month  <= MONTH_FIRST;
            r_clk.day    <= DAY_FIRST;
            r_clk.hour   <= '0;
            r_clk.minute <= '0;
            r_clk.second <= '0;
        end else if (take) begin
            r_vld <= 1'b1;
            r_clk <= n_clk;
        end else if (i_rdy) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rej  <= n_rej;
            r_roll <= n_roll;
        end
    end

    assign o_vld            = r_vld;
    assign o_stamp.clk      = r_clk;
    assign o_stamp.rejected = r_rej;
    assign o_stamp.rolled   = r_roll;

endmodule

>>> rtl/ccw_weekday.sv
// ----------------------------------------------------------------------------
// ccw_weekday: day-of-week pipeline
// Two stages: year and month terms with the century quotient, then mod 7.
// ----------------------------------------------------------------------------
module ccw_weekday
    import ccw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_vld,
    input  t_stamp    i_stamp,
    output logic      o_rdy,
    output logic      o_vld,
    output t_out_item o_item,
    input  logic      i_rdy
);

    localparam logic [12:0] RECIP_25 = 13'd5243;
    localparam int          RECIP_SH = 17;

    typedef struct packed {
        t_stamp      stamp;
        logic [16:0] yy;
        logic [9:0]  q100;
        logic [5:0]  mday;
    } t_wd_mid;

    // month term (2m + 3(m+1)/5) mod 7, Jan and Feb as months 13 and 14
    function automatic logic [2:0] month_term(input logic [3:0] m);
        logic [2:0] t;
        case (m)
            4'd1:    t = 3'd6;
            4'd2:    t = 3'd2;
            4'd3:    t = 3'd1;
            4'd4:    t = 3'd4;
            4'd5:    t = 3'd6;
            4'd6:    t = 3'd2;
            4'd7:    t = 3'd4;
            4'd8:    t = 3'd0;
            4'd9:    t = 3'd3;
            4'd10:   t = 3'd5;
            4'd11:   t = 3'd1;
            4'd12:   t = 3'd3;
            default: t = 3'd0;
        endcase
        return t;
    endfunction

    t_wd_mid     r_mid, n_mid;
    t_out_item   r_out, n_out;
    logic        r_mid_vld, r_out_vld;
    logic        mid_rdy, out_rdy;
    logic [16:0] yy;
    logic [27:0] prod;
    logic [17:0] sum;
    logic [5:0]  f1;
    logic [3:0]  f2;

    // stage 1
    always_comb begin
        yy = 17'(i_stamp.clk.year) + 17'd400;
        if (i_stamp.clk.month <= MONTH_FEB) begin
            yy = yy - 17'd1;
        end
        prod        = 28'(yy[16:2]) * 28'(RECIP_25);
        n_mid.stamp = i_stamp;
        n_mid.yy    = yy;
        n_mid.q100  = prod[RECIP_SH +: 10];
        n_mid.mday  = 6'(i_stamp.clk.day) + 6'(month_term(i_stamp.clk.month));
    end

    // stage 2: 8 = 1 mod 7, so fold octal digits
    always_comb begin
        sum = 18'(r_mid.yy) + 18'(r_mid.yy[16:2]) + 18'(r_mid.q100[9:2])
            + 18'(r_mid.mday) - 18'(r_mid.q100);
        f1  = 6'(sum[2:0]) + 6'(sum[5:3]) + 6'(sum[8:6])
            + 6'(sum[11:9]) + 6'(sum[14:12]) + 6'(sum[17:15]);
        f2  = 4'(f1[2:0]) + 4'(f1[5:3]);
        n_out.cur_year     = r_mid.stamp.clk.year;
        n_out.cur_month    = r_mid.stamp.clk.month;
        n_out.cur_day      = r_mid.stamp.clk.day;
        n_out.cur_hour     = r_mid.stamp.clk.hour;
        n_out.cur_minute   = r_mid.stamp.clk.minute;
        n_out.cur_second   = r_mid.stamp.clk.second;
        n_out.weekday      = (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
        n_out.set_rejected = r_mid.stamp.rejected;
        n_out.day_rolled   = r_mid.stamp.rolled;
    end

    assign out_rdy = !r_out_vld || i_rdy;
    assign mid_rdy = !r_mid_vld || out_rdy;
    assign o_rdy   = mid_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (mid_rdy) begin
                r_mid_vld <= i_vld;
            end
            if (out_rdy) begin
                r_out_vld <= r_mid_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mid_rdy && i_vld) begin
            r_mid <= n_mid;
        end
        if (out_rdy && r_mid_vld) begin
            r_out <= n_out;
        end
    end

    assign o_vld  = r_out_vld;
    assign o_item = r_out;

endmodule

>>> rtl/ccw_checker.sv
// ----------------------------------------------------------------------------
// ccw_checker: port-level checks for the calendar clock
// Result ranges, flag consistency and result hold under stall.
// ----------------------------------------------------------------------------
module ccw_checker
    import ccw_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result dropped or changed while stalled");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.set_rejected && o_out_item.day_rolled))
        else $error("rejected set flagged as day rollover");

    a_rollover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.day_rolled |->
            o_out_item.cur_hour == '0 && o_out_item.cur_minute == '0
            && o_out_item.cur_second == '0)
        else $error("day rollover not at midnight");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_out_item.cur_month >= MONTH_FIRST && o_out_item.cur_month <= MONTH_LAST
            && o_out_item.cur_day >= DAY_FIRST && o_out_item.cur_hour <= HOUR_LAST
            && o_out_item.cur_minute <= MIN_LAST && o_out_item.cur_second <= SEC_LAST
            && o_out_item.weekday <= WDAY_LAST)
        else $error("result field out of range");

endmodule

bind calendar_clock_with_weekday ccw_checker u_ccw_checker (.*);
